// ===== rtl/mqttfh_pkg.sv =====
// ----------------------------------------------------------------------------
// mqttfh_pkg
// Types and constants shared by the fixed-header deframer.
// ----------------------------------------------------------------------------
package mqttfh_pkg;

    localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;
    localparam int unsigned LEN_W                = 28;
    localparam int unsigned LCNT_W               = 2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RG_HEADER = 2'd0,
        RG_LENGTH = 2'd1,
        RG_BODY   = 2'd2
    } t_region;

endpackage

// ===== rtl/mqtt_fixed_header_deframer.sv =====
// An accepted input transaction passes through the input register, then the result register.
// Throughput: one byte per cycle, sustained under no back-pressure; the
// 28-bit length add and its zero compare set the critical path.
// An input register and a result register; input ready follows result ready when both are full.
// Reset (synchronous, active low) returns the block to the header phase
// and empties both registers.
// ----------------------------------------------------------------------------
// mqtt_fixed_header_deframer
// Splits a packet byte stream into header, remaining-length and body bytes.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer #(
    parameter int unsigned MAX_LENGTH_BYTES = mqttfh_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_stream_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_data_byte,
    output logic [1:0]                   o_region,
    output logic [3:0]                   o_packet_type,
    output logic [3:0]                   o_header_flags,
    output logic [mqttfh_pkg::LEN_W-1:0] o_remaining_length,
    output logic [mqttfh_pkg::LEN_W-1:0] o_body_offset,
    output logic                         o_packet_end,
    output logic                         o_length_error
);

    localparam int unsigned LW = mqttfh_pkg::LEN_W;
    localparam int unsigned CW = mqttfh_pkg::LCNT_W;
    localparam logic [CW-1:0] LAST_LEN = CW'(MAX_LENGTH_BYTES - 1);

    mqttfh_pkg::t_phase r_phase, n_phase;
    logic [3:0]    r_type, n_type;
    logic [3:0]    r_flags, n_flags;
    logic [LW-1:0] r_acc, n_acc;
    logic [CW-1:0] r_lcnt, n_lcnt;
    logic [LW-1:0] r_bcnt, n_bcnt;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;

    logic          r_out_valid;
    logic [7:0]    r_data_byte;
    logic [1:0]    r_region;
    logic [3:0]    r_ptype;
    logic [3:0]    r_pflags;
    logic [LW-1:0] r_rlen;
    logic [LW-1:0] r_offs;
    logic          r_end;
    logic          r_err;

    logic          advance;
    logic [LW-1:0] addend;
    logic [LW-1:0] acc_sum;
    logic [LW-1:0] bcnt_inc;
    logic [1:0]    n_region;
    logic [LW-1:0] n_rlen;
    logic [LW-1:0] n_offs;
    logic          n_end;
    logic          n_err;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        case (r_lcnt)
            2'd0:    addend = {{(LW-7){1'b0}}, r_in_byte[6:0]};
            2'd1:    addend = {{(LW-14){1'b0}}, r_in_byte[6:0], 7'd0};
            2'd2:    addend = {{(LW-21){1'b0}}, r_in_byte[6:0], 14'd0};
            default: addend = {r_in_byte[6:0], 21'd0};
        endcase
    end

    assign acc_sum  = r_acc + addend;
    assign bcnt_inc = r_bcnt + LW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_flags  = r_flags;
        n_acc    = r_acc;
        n_lcnt   = r_lcnt;
        n_bcnt   = r_bcnt;
        n_region = mqttfh_pkg::RG_HEADER;
        n_rlen   = '0;
        n_offs   = '0;
        n_end    = 1'b0;
        n_err    = 1'b0;
        case (r_phase)
            mqttfh_pkg::PH_LENGTH: begin
                n_acc    = acc_sum;
                n_region = mqttfh_pkg::RG_LENGTH;
                n_rlen   = acc_sum;
                if (r_in_byte[7]) begin
                    if (r_lcnt >= LAST_LEN) begin
                        n_err   = 1'b1;
                        n_phase = mqttfh_pkg::PH_HEADER;
                    end else begin
                        n_lcnt = r_lcnt + CW'(1);
                    end
                end else if (acc_sum == '0) begin
                    n_end   = 1'b1;
                    n_phase = mqttfh_pkg::PH_HEADER;
                end else begin
                    n_bcnt  = '0;
                    n_phase = mqttfh_pkg::PH_BODY;
                end
            end
            mqttfh_pkg::PH_BODY: begin
                n_region = mqttfh_pkg::RG_BODY;
                n_rlen   = r_acc;
                n_offs   = r_bcnt;
                if (bcnt_inc == r_acc) begin
                    n_end   = 1'b1;
                    n_phase = mqttfh_pkg::PH_HEADER;
                end else begin
                    n_bcnt = bcnt_inc;
                end
            end
            default: begin
                n_type  = r_in_byte[7:4];
                n_flags = r_in_byte[3:0];
                n_acc   = '0;
                n_lcnt  = '0;
                n_bcnt  = '0;
                n_phase = mqttfh_pkg::PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mqttfh_pkg::PH_HEADER;
            r_type  <= '0;
            r_flags <= '0;
            r_acc   <= '0;
            r_lcnt  <= '0;
            r_bcnt  <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_flags <= n_flags;
            r_acc   <= n_acc;
            r_lcnt  <= n_lcnt;
            r_bcnt  <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data_byte <= r_in_byte;
            r_region    <= n_region;
            r_ptype     <= n_type;
            r_pflags    <= n_flags;
            r_rlen      <= n_rlen;
            r_offs      <= n_offs;
            r_end       <= n_end;
            r_err       <= n_err;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_data_byte        = r_data_byte;
    assign o_region           = r_region;
    assign o_packet_type      = r_ptype;
    assign o_header_flags     = r_pflags;
    assign o_remaining_length = r_rlen;
    assign o_body_offset      = r_offs;
    assign o_packet_end       = r_end;
    assign o_length_error     = r_err;

    a_body_offset_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region == mqttfh_pkg::RG_BODY) |-> (o_body_offset < o_remaining_length))
        else $error("Body offset is not below the remaining length.");

    a_error_on_length_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_error) |-> (o_region == mqttfh_pkg::RG_LENGTH && !o_packet_end))
        else $error("Length error reported outside a length byte.");

    a_header_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region == mqttfh_pkg::RG_HEADER)
            |-> (!o_packet_end && o_remaining_length == '0 && o_body_offset == '0))
        else $error("Header byte carries length or end marking.");

    a_header_follows_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_end || n_err)) |=> (r_phase == mqttfh_pkg::PH_HEADER))
        else $error("Block did not return to the header phase after a packet end.");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-header deframer. Streams directed and
// random packets through the block. Every output transaction is compared
// field by field with an expected byte tag worked out by an in-bench
// predictor. Idling on both channels varies across the run.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [7:0]                   data;
        mqttfh_pkg::t_region          region;
        logic [3:0]                   ptype;
        logic [3:0]                   flags;
        logic [mqttfh_pkg::LEN_W-1:0] rlen;
        logic [mqttfh_pkg::LEN_W-1:0] offs;
        logic                         pend;
        logic                         err;
    } t_byte_tag;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [7:0]                   i_stream_byte = 8'h00;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [7:0]                   o_data_byte;
    logic [1:0]                   o_region;
    logic [3:0]                   o_packet_type;
    logic [3:0]                   o_header_flags;
    logic [mqttfh_pkg::LEN_W-1:0] o_remaining_length;
    logic [mqttfh_pkg::LEN_W-1:0] o_body_offset;
    logic                         o_packet_end;
    logic                         o_length_error;

    logic [7:0]  pending_bytes [$];
    t_byte_tag   expected_tags [$];
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;

    mqttfh_pkg::t_phase            fh_phase = mqttfh_pkg::PH_HEADER;
    logic [3:0]                    fh_type = '0;
    logic [3:0]                    fh_flags = '0;
    logic [mqttfh_pkg::LEN_W-1:0]  fh_len_acc = '0;
    logic [mqttfh_pkg::LCNT_W-1:0] fh_len_cnt = '0;
    logic [mqttfh_pkg::LEN_W-1:0]  fh_body_cnt = '0;

    logic [7:0] directed_bytes [22] = '{
        8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h3A, 8'h02, 8'h00, 8'hFF,
        8'h5C, 8'h80, 8'h00,
        8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
        8'hC6, 8'h01, 8'h7E
    };

    mqtt_fixed_header_deframer DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_stream_byte      (i_stream_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_data_byte        (o_data_byte),
        .o_region           (o_region),
        .o_packet_type      (o_packet_type),
        .o_header_flags     (o_header_flags),
        .o_remaining_length (o_remaining_length),
        .o_body_offset      (o_body_offset),
        .o_packet_end       (o_packet_end),
        .o_length_error     (o_length_error)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_byte_tag classify_byte(input logic [7:0] b);
        t_byte_tag   tag;
        int unsigned k;
        tag = '0;
        tag.data = b;
        case (fh_phase)
            mqttfh_pkg::PH_LENGTH: begin
                k = fh_len_cnt;
                fh_len_acc = fh_len_acc + (mqttfh_pkg::LEN_W'(b[6:0]) << (7 * k));
                tag.region = mqttfh_pkg::RG_LENGTH;
                tag.rlen = fh_len_acc;
                if (b[7]) begin
                    if (k + 1 >= mqttfh_pkg::MAX_LENGTH_BYTES_DEF) begin
                        tag.err = 1'b1;
                        fh_phase = mqttfh_pkg::PH_HEADER;
                    end else begin
                        fh_len_cnt = mqttfh_pkg::LCNT_W'(k + 1);
                    end
                end else if (fh_len_acc == '0) begin
                    tag.pend = 1'b1;
                    fh_phase = mqttfh_pkg::PH_HEADER;
                end else begin
                    fh_body_cnt = '0;
                    fh_phase = mqttfh_pkg::PH_BODY;
                end
            end
            mqttfh_pkg::PH_BODY: begin
                tag.region = mqttfh_pkg::RG_BODY;
                tag.rlen = fh_len_acc;
                tag.offs = fh_body_cnt;
                if (fh_body_cnt + mqttfh_pkg::LEN_W'(1) == fh_len_acc) begin
                    tag.pend = 1'b1;
                    fh_phase = mqttfh_pkg::PH_HEADER;
                end else begin
                    fh_body_cnt = fh_body_cnt + mqttfh_pkg::LEN_W'(1);
                end
            end
            default: begin
                fh_type = b[7:4];
                fh_flags = b[3:0];
                fh_len_acc = '0;
                fh_len_cnt = '0;
                fh_body_cnt = '0;
                fh_phase = mqttfh_pkg::PH_LENGTH;
                tag.region = mqttfh_pkg::RG_HEADER;
            end
        endcase
        tag.ptype = fh_type;
        tag.flags = fh_flags;
        return tag;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
        mismatch_count++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        pending_bytes = {pending_bytes, b};
    endtask

    task automatic put_tag(input t_byte_tag tag);
        expected_tags = {expected_tags, tag};
    endtask

    // A length is encoded in its minimal number of bytes plus the requested
    // padding, capped at the largest encoding that the block allows.
    task automatic queue_packet(input logic [7:0] hdr, input int unsigned body_len,
                                input int unsigned pad);
        int unsigned n;
        n = (body_len < 128) ? 1 : (body_len < 16384) ? 2 : (body_len < 2097152) ? 3 : 4;
        n = (n + pad > mqttfh_pkg::MAX_LENGTH_BYTES_DEF) ? mqttfh_pkg::MAX_LENGTH_BYTES_DEF
                                                         : n + pad;
        put_byte(hdr);
        for (int k = 0; k < n; k++) begin
            put_byte({(k < n - 1) ? 1'b1 : 1'b0, 7'((body_len >> (7 * k)) & 127)});
        end
        repeat (body_len) put_byte(8'($urandom));
    endtask

    task automatic queue_overrun(input logic [7:0] hdr, input logic [27:0] groups);
        put_byte(hdr);
        for (int k = 0; k < 4; k++) begin
            put_byte({1'b1, groups[7 * k +: 7]});
        end
    endtask

    task automatic queue_random_packets(input int unsigned n_items);
        int unsigned sel;
        while (pending_bytes.size() < n_items) begin
            sel = $urandom_range(99);
            if (sel < 10) begin
                queue_packet(8'($urandom), 0, $urandom_range(3));
            end else if (sel < 70) begin
                queue_packet(8'($urandom), $urandom_range(16, 1), 0);
            end else if (sel < 80) begin
                queue_packet(8'($urandom), $urandom_range(300, 17), 0);
            end else if (sel < 90) begin
                queue_packet(8'($urandom), $urandom_range(40, 1), $urandom_range(3, 1));
            end else begin
                queue_overrun(8'($urandom), 28'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                put_tag(classify_byte(i_stream_byte));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_stream_byte <= pending_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_byte_tag want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tags.size() == 0) begin
                note_mismatch("unexpected transaction", o_data_byte, 0);
            end else begin
                want = expected_tags.pop_front();
                if (o_data_byte !== want.data)
                    note_mismatch("data_byte", o_data_byte, want.data);
                if (o_region !== want.region)
                    note_mismatch("region", o_region, want.region);
                if (o_packet_type !== want.ptype)
                    note_mismatch("packet_type", o_packet_type, want.ptype);
                if (o_header_flags !== want.flags)
                    note_mismatch("header_flags", o_header_flags, want.flags);
                if (o_remaining_length !== want.rlen)
                    note_mismatch("remaining_length", o_remaining_length, want.rlen);
                if (o_body_offset !== want.offs)
                    note_mismatch("body_offset", o_body_offset, want.offs);
                if (o_packet_end !== want.pend)
                    note_mismatch("packet_end", o_packet_end, want.pend);
                if (o_length_error !== want.err)
                    note_mismatch("length_error", o_length_error, want.err);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_bytes[i]) put_byte(directed_bytes[i]);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            queue_random_packets(220);
            // Unframed bytes go last, as they may leave the block deep in a body.
            if (ph == 3) begin
                repeat (40) put_byte(8'($urandom));
            end
            while (pending_bytes.size() != 0) @(posedge i_clk);
        end
        while (i_in_valid || expected_tags.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tags.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
